>>> design/arrlt_pkg.sv
// Shared types and constants for the address range reverse lookup table.
package arrlt_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int ADDR_BITS = 48;
	localparam int FIELD_ADDR_W = 48;
	localparam int BYTES_W = 48;
	localparam int HANDLE_W = 32;
	localparam int FLAGS_W = 32;
	localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_IGNORED   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} arrlt_status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_LOOKUP = 1'b1
	} arrlt_action_t;

	typedef struct packed {
		logic                 valid;
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS-1:0] stop;
		logic [HANDLE_W-1:0]  handle;
		logic [FLAGS_W-1:0]   flags;
	} arrlt_entry_t;

	typedef struct packed {
		logic                 en;
		logic                 all;
		logic [IDX_BITS-1:0]  idx;
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS-1:0] stop;
		logic [HANDLE_W-1:0]  handle;
		logic [FLAGS_W-1:0]   flags;
	} arrlt_wr_t;

	typedef struct packed {
		arrlt_status_t        status;
		logic [HANDLE_W-1:0]  handle;
		logic [ADDR_BITS-1:0] stop;
		logic [FLAGS_W-1:0]   flags;
	} arrlt_result_t;

endpackage

>>> design/arrlt_store.sv
// Region table storage: field memories with registered read and per-entry valid flops.
module arrlt_store import arrlt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IDX_BITS-1:0] rd_addr,
	input  arrlt_wr_t           wr,
	output arrlt_entry_t        rd
);

	logic [ADDR_BITS-1:0] mem_start [TABLE_ENTRIES];
	logic [ADDR_BITS-1:0] mem_stop [TABLE_ENTRIES];
	logic [HANDLE_W-1:0]  mem_handle [TABLE_ENTRIES];
	logic [FLAGS_W-1:0]   mem_flags [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic                 rd_valid_q;
	logic [ADDR_BITS-1:0] rd_start_q;
	logic [ADDR_BITS-1:0] rd_stop_q;
	logic [HANDLE_W-1:0]  rd_handle_q;
	logic [FLAGS_W-1:0]   rd_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (wr.en && wr.all) begin
				valid_q[wr.idx] <= 1'b1;
			end
		end
	end

	// write start and handle only for a new region; end and flags always
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_stop[wr.idx] <= wr.stop;
			mem_flags[wr.idx] <= wr.flags;
			if (wr.all) begin
				mem_start[wr.idx] <= wr.start;
				mem_handle[wr.idx] <= wr.handle;
			end
		end
		rd_start_q <= mem_start[rd_addr];
		rd_stop_q <= mem_stop[rd_addr];
		rd_handle_q <= mem_handle[rd_addr];
		rd_flags_q <= mem_flags[rd_addr];
	end

	assign rd.valid = rd_valid_q;
	assign rd.start = rd_start_q;
	assign rd.stop = rd_stop_q;
	assign rd.handle = rd_handle_q;
	assign rd.flags = rd_flags_q;

endmodule

>>> design/arrlt_seq.sv
// Scan sequencer: walks the table one entry per cycle through a shared compare unit.
module arrlt_seq import arrlt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic [FIELD_ADDR_W-1:0] address,
	input  logic [FIELD_ADDR_W-1:0] end_address,
	input  logic [HANDLE_W-1:0]     resource_handle,
	input  logic [BYTES_W-1:0]      resource_bytes,
	input  logic [FLAGS_W-1:0]      state_word,
	input  logic [FIELD_ADDR_W-1:0] min_size,
	output logic [IDX_BITS-1:0]     rd_addr,
	input  arrlt_entry_t            rd,
	output arrlt_wr_t               wr,
	output logic                    res_valid,
	input  logic                    res_take,
	output arrlt_result_t           res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t               state_q;
	arrlt_action_t        op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] stop_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [FLAGS_W-1:0]   flags_q;
	logic [ADDR_BITS:0]   reach_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 pend_s1;
	logic [IDX_BITS-1:0]  idx_s1;
	logic                 hit_q;
	logic [IDX_BITS-1:0]  hit_idx_q;
	logic                 free_q;
	logic [IDX_BITS-1:0]  free_idx_q;
	logic [ADDR_BITS-1:0] best_start_q;
	logic [ADDR_BITS-1:0] best_stop_q;
	logic [HANDLE_W-1:0]  best_handle_q;
	logic [FLAGS_W-1:0]   best_flags_q;
	arrlt_status_t        status_q;

	logic                 accept;
	logic [ADDR_BITS-1:0] in_addr;
	logic [ADDR_BITS-1:0] in_min;
	logic                 issuing;
	logic                 scan_done;
	logic                 same_region;
	logic                 covers;
	logic                 better;

	assign accept = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign in_addr = address[ADDR_BITS-1:0];
	assign in_min = min_size[ADDR_BITS-1:0];
	assign issuing = (cnt_q < CNT_BITS'(TABLE_ENTRIES));
	assign scan_done = (state_q == S_SCAN) && !issuing && !pend_s1;
	assign rd_addr = cnt_q[IDX_BITS-1:0];

	// shared compare unit, applied to the entry read back this cycle
	assign same_region = rd.valid && (rd.start == addr_q) && (rd.handle == handle_q);
	assign covers = rd.valid && (rd.start <= addr_q) && (addr_q < rd.stop)
		&& (reach_q <= {1'b0, rd.stop});
	assign better = !hit_q || (rd.start > best_start_q);

	always_comb begin
		wr.en = scan_done && (op_q == ACT_INSERT) && (hit_q || free_q);
		wr.all = !hit_q;
		wr.idx = hit_q ? hit_idx_q : free_idx_q;
		wr.start = addr_q;
		wr.stop = stop_q;
		wr.handle = handle_q;
		wr.flags = flags_q;
	end

	assign res_valid = (state_q == S_FINISH);
	always_comb begin
		res.status = status_q;
		res.handle = '0;
		res.stop = '0;
		res.flags = '0;
		if (op_q == ACT_LOOKUP && hit_q) begin
			res.handle = best_handle_q;
			res.stop = best_stop_q;
			res.flags = best_flags_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= ACT_INSERT;
			addr_q <= '0;
			stop_q <= '0;
			handle_q <= '0;
			flags_q <= '0;
			reach_q <= '0;
			cnt_q <= '0;
			pend_s1 <= 1'b0;
			idx_s1 <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			free_q <= 1'b0;
			free_idx_q <= '0;
			best_start_q <= '0;
			best_stop_q <= '0;
			best_handle_q <= '0;
			best_flags_q <= '0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= arrlt_action_t'(action);
						addr_q <= in_addr;
						stop_q <= end_address[ADDR_BITS-1:0];
						handle_q <= resource_handle;
						flags_q <= state_word;
						reach_q <= {1'b0, in_addr} + {1'b0, in_min};
						cnt_q <= '0;
						pend_s1 <= 1'b0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						if (action == ACT_INSERT) begin
							if (resource_handle == '0 || resource_bytes == '0
								|| in_addr == '0) begin
								status_q <= ST_IGNORED;
								state_q <= S_FINISH;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							if (in_addr == '0) begin
								status_q <= ST_NOT_FOUND;
								state_q <= S_FINISH;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					// advance the read address; data returns in the next cycle
					pend_s1 <= issuing;
					idx_s1 <= cnt_q[IDX_BITS-1:0];
					if (issuing) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (pend_s1) begin
						if (op_q == ACT_INSERT) begin
							if (same_region && !hit_q) begin
								hit_q <= 1'b1;
								hit_idx_q <= idx_s1;
							end
							if (!rd.valid && !free_q) begin
								free_q <= 1'b1;
								free_idx_q <= idx_s1;
							end
						end else if (covers && better) begin
							hit_q <= 1'b1;
							best_start_q <= rd.start;
							best_stop_q <= rd.stop;
							best_handle_q <= rd.handle;
							best_flags_q <= rd.flags;
						end
					end
					if (scan_done) begin
						if (op_q == ACT_INSERT) begin
							status_q <= (hit_q || free_q) ? ST_OK : ST_FULL;
						end else begin
							status_q <= hit_q ? ST_OK : ST_NOT_FOUND;
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/address_range_reverse_lookup_table.sv
// Top level of the address range reverse lookup table: sequencer, table storage, output register.
//
// The block keeps a table of TABLE_ENTRIES address regions (start, exclusive end,
// resource handle, state word). An insert word updates the region with the same
// start and handle, or fills the lowest free slot, and reports table full when
// neither exists; a zero handle, zero size or zero start is ignored. A lookup word
// returns the region with the greatest start not above the address whose end lies
// beyond the address and at least min_size past it; among equal starts the lowest
// slot wins, and address zero or no match reports not found. Every word gives
// exactly one result word. A word that is rejected up front (ignored insert,
// lookup of address zero) skips the table sweep; every other word waits while
// the table is swept one entry per cycle through the single read port of the
// region memories and one shared compare unit. in_stall stays high from accept
// until the result moves into the output register. The result sits in
// an output register, so the next word is accepted while a finished result still
// waits on out_stall. After reset the table is empty; no clearing pass is needed.
module address_range_reverse_lookup_table import arrlt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic [FIELD_ADDR_W-1:0] address,
	input  logic [FIELD_ADDR_W-1:0] end_address,
	input  logic [HANDLE_W-1:0]     resource_handle,
	input  logic [BYTES_W-1:0]      resource_bytes,
	input  logic [FLAGS_W-1:0]      state_word,
	input  logic [FIELD_ADDR_W-1:0] min_size,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [HANDLE_W-1:0]     found_handle,
	output logic [FIELD_ADDR_W-1:0] found_end,
	output logic [FLAGS_W-1:0]      found_state
);

	logic [IDX_BITS-1:0] rd_addr;
	arrlt_entry_t        rd;
	arrlt_wr_t           wr;
	logic                res_valid;
	logic                res_take;
	arrlt_result_t       res;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [ADDR_BITS-1:0] stop_q;
	logic [FLAGS_W-1:0]   flags_q;

	// Sequencer: holds the accepted word and runs the table sweep.
	arrlt_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.address         (address),
		.end_address     (end_address),
		.resource_handle (resource_handle),
		.resource_bytes  (resource_bytes),
		.state_word      (state_word),
		.min_size        (min_size),
		.rd_addr         (rd_addr),
		.rd              (rd),
		.wr              (wr),
		.res_valid       (res_valid),
		.res_take        (res_take),
		.res             (res)
	);

	// Region storage: one read port for the sweep, one write port at its end.
	arrlt_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd      (rd)
	);

	// Take a finished result whenever the output register is empty or draining.
	assign res_take = !out_valid_q || !out_stall;

	// Hold the result word until the consumer takes it; drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			status_q <= res.status;
			handle_q <= res.handle;
			stop_q <= res.stop;
			flags_q <= res.flags;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign found_handle = handle_q;
	assign found_end = FIELD_ADDR_W'(stop_q);
	assign found_state = flags_q;

endmodule

>>> tb/address_range_reverse_lookup_table_tb.sv
// Self-checking testbench for the address range reverse lookup table.
module address_range_reverse_lookup_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import arrlt_pkg::*;

	localparam int POOL_STARTS      = 12;
	localparam int POOL_HANDLES     = 4;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 40;

	localparam logic [FIELD_ADDR_W-1:0] ADDR_TOP   = '1;
	localparam logic [HANDLE_W-1:0]     HANDLE_TOP = '1;
	localparam logic [BYTES_W-1:0]      BYTES_TOP  = '1;
	localparam logic [FLAGS_W-1:0]      FLAGS_TOP  = '1;

	// Shadow copy of the region table plus the queue of results it predicts.
	// Every accepted input word is noted once; every accepted result word is
	// checked against the oldest prediction.
	class region_table_scoreboard;
		bit                 slot_used   [TABLE_ENTRIES];
		bit [ADDR_BITS-1:0] slot_start  [TABLE_ENTRIES];
		bit [ADDR_BITS-1:0] slot_end    [TABLE_ENTRIES];
		bit [HANDLE_W-1:0]  slot_handle [TABLE_ENTRIES];
		bit [FLAGS_W-1:0]   slot_flags  [TABLE_ENTRIES];
		arrlt_result_t      expected_results[$];
		int                 mismatches;
		int                 results_seen;

		function int free_slots();
			int n = 0;
			foreach (slot_used[i])
				if (!slot_used[i])
					n++;
			return n;
		endfunction

		function void note_word(arrlt_action_t act, bit [ADDR_BITS-1:0] addr,
				bit [ADDR_BITS-1:0] stop, bit [HANDLE_W-1:0] handle,
				bit [BYTES_W-1:0] bytes, bit [FLAGS_W-1:0] flags,
				bit [ADDR_BITS-1:0] min_bytes);
			arrlt_result_t    r;
			int               hit;
			int               i;
			bit [ADDR_BITS:0] reach;
			r = '0;
			hit = -1;
			if (act == ACT_INSERT) begin
				if (handle == '0 || bytes == '0 || addr == '0) begin
					r.status = ST_IGNORED;
				end else begin
					// same start and handle: refresh end and flags in place
					for (i = 0; i < TABLE_ENTRIES; i++)
						if (hit < 0 && slot_used[i] && slot_start[i] == addr &&
								slot_handle[i] == handle)
							hit = i;
					if (hit >= 0) begin
						slot_end[hit]   = stop;
						slot_flags[hit] = flags;
						r.status        = ST_OK;
					end else begin
						for (i = 0; i < TABLE_ENTRIES; i++)
							if (hit < 0 && !slot_used[i])
								hit = i;
						if (hit < 0) begin
							r.status = ST_FULL;
						end else begin
							slot_used[hit]   = 1'b1;
							slot_start[hit]  = addr;
							slot_end[hit]    = stop;
							slot_handle[hit] = handle;
							slot_flags[hit]  = flags;
							r.status         = ST_OK;
						end
					end
				end
			end else begin
				// the reach is one bit wider so that it never wraps
				reach = {1'b0, addr} + {1'b0, min_bytes};
				if (addr != '0)
					for (i = 0; i < TABLE_ENTRIES; i++)
						if (slot_used[i] && slot_start[i] <= addr && addr < slot_end[i] &&
								reach <= {1'b0, slot_end[i]} &&
								(hit < 0 || slot_start[i] > slot_start[hit]))
							hit = i;
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.status = ST_OK;
					r.handle = slot_handle[hit];
					r.stop   = slot_end[hit];
					r.flags  = slot_flags[hit];
				end
			end
			expected_results.push_back(r);
		endfunction

		task flag_mismatch(string what);
			mismatches++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_result(logic [1:0] got_status, logic [HANDLE_W-1:0] got_handle,
				logic [ADDR_BITS-1:0] got_end, logic [FLAGS_W-1:0] got_flags);
			arrlt_result_t want;
			results_seen++;
			if (expected_results.size() == 0) begin
				flag_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
				return;
			end
			want = expected_results.pop_front();
			if (got_status !== want.status)
				flag_mismatch($sformatf("result %0d status %0d, want %0d",
					results_seen, got_status, want.status));
			if (got_handle !== want.handle)
				flag_mismatch($sformatf("result %0d found_handle %h, want %h",
					results_seen, got_handle, want.handle));
			if (got_end !== want.stop)
				flag_mismatch($sformatf("result %0d found_end %h, want %h",
					results_seen, got_end, want.stop));
			if (got_flags !== want.flags)
				flag_mismatch($sformatf("result %0d found_state %h, want %h",
					results_seen, got_flags, want.flags));
		endtask
	endclass

	// Every input starts at a known value.
	logic                    clk             = 1'b0;
	logic                    arst_n          = 1'b0;
	logic                    in_valid        = 1'b0;
	logic                    in_stall;
	logic                    action          = 1'b0;
	logic [FIELD_ADDR_W-1:0] address         = '0;
	logic [FIELD_ADDR_W-1:0] end_address     = '0;
	logic [HANDLE_W-1:0]     resource_handle = '0;
	logic [BYTES_W-1:0]      resource_bytes  = '0;
	logic [FLAGS_W-1:0]      state_word      = '0;
	logic [FIELD_ADDR_W-1:0] min_size        = '0;
	logic                    out_valid;
	logic                    out_stall       = 1'b0;
	logic [1:0]              status;
	logic [HANDLE_W-1:0]     found_handle;
	logic [FIELD_ADDR_W-1:0] found_end;
	logic [FLAGS_W-1:0]      found_state;

	// quiet drops all random idling on both sides; long_hold_req asks the
	// result side for one long stall.
	bit quiet         = 1'b0;
	bit long_hold_req = 1'b0;

	region_table_scoreboard regions = new();

	// Region starts and handles reused by random inserts, so that updates,
	// aliases at one start and a full table all come up.
	logic [FIELD_ADDR_W-1:0] pool_start  [POOL_STARTS];
	logic [HANDLE_W-1:0]     pool_handle [POOL_HANDLES];

	address_range_reverse_lookup_table u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.address         (address),
		.end_address     (end_address),
		.resource_handle (resource_handle),
		.resource_bytes  (resource_bytes),
		.state_word      (state_word),
		.min_size        (min_size),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.found_handle    (found_handle),
		.found_end       (found_end),
		.found_state     (found_state)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#1_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [FIELD_ADDR_W-1:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[FIELD_ADDR_W-1:0];
	endfunction

	// Offer one word and hold it until taken. Handshakes are sampled at the
	// falling edge, where every signal is settled; the word is taken at the
	// next rising edge if in_stall is low. Called and returns at a rising edge.
	task automatic send_word(arrlt_action_t act, logic [FIELD_ADDR_W-1:0] addr,
			logic [FIELD_ADDR_W-1:0] stop, logic [HANDLE_W-1:0] handle,
			logic [BYTES_W-1:0] bytes, logic [FLAGS_W-1:0] flags,
			logic [FIELD_ADDR_W-1:0] min_bytes);
		bit taken;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid        <= 1'b1;
		action          <= act;
		address         <= addr;
		end_address     <= stop;
		resource_handle <= handle;
		resource_bytes  <= bytes;
		state_word      <= flags;
		min_size        <= min_bytes;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			if (taken)
				regions.note_word(act, addr, stop, handle, bytes, flags, min_bytes);
			@(posedge clk);
		end
	endtask

	// Fields a word does not use are still driven at random.
	task automatic send_insert(logic [FIELD_ADDR_W-1:0] start, logic [FIELD_ADDR_W-1:0] stop,
			logic [HANDLE_W-1:0] handle, logic [BYTES_W-1:0] bytes,
			logic [FLAGS_W-1:0] flags);
		send_word(ACT_INSERT, start, stop, handle, bytes, flags, rand48());
	endtask

	task automatic send_lookup(logic [FIELD_ADDR_W-1:0] addr,
			logic [FIELD_ADDR_W-1:0] min_bytes);
		send_word(ACT_LOOKUP, addr, rand48(), $urandom, rand48(), $urandom, min_bytes);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic wait_drained(int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (regions.expected_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Mostly well-formed traffic: inserts drawn from the pools and lookups aimed
	// inside a region already in the table; the rest is noise.
	task automatic send_random_word();
		int                      pick;
		int                      slot;
		int                      used;
		logic [FIELD_ADDR_W-1:0] base;
		logic [FIELD_ADDR_W-1:0] stop;
		logic [FIELD_ADDR_W-1:0] span;
		logic [FIELD_ADDR_W-1:0] addr;
		logic [FIELD_ADDR_W-1:0] room;
		logic [FIELD_ADDR_W-1:0] min_bytes;
		logic [HANDLE_W-1:0]     handle;
		logic [BYTES_W-1:0]      bytes;
		pick = $urandom_range(0, 99);
		used = TABLE_ENTRIES - regions.free_slots();
		if (pick < 45) begin
			base = pool_start[$urandom_range(0, POOL_STARTS - 1)];
			case ($urandom_range(0, 7))
				0:       stop = rand48();
				1:       stop = base;
				default: stop = base + $urandom_range(1, 'h3000);
			endcase
			handle = ($urandom_range(0, 15) == 0) ? '0 :
				pool_handle[$urandom_range(0, POOL_HANDLES - 1)];
			bytes = ($urandom_range(0, 15) == 0) ? '0 : rand48();
			send_insert(base, stop, handle, bytes, $urandom);
		end else if (pick < 85) begin
			// slots fill from the bottom and are never freed, so 0..used-1 hold regions
			slot = (used > 0) ? $urandom_range(0, used - 1) : 0;
			if (used > 0 && regions.slot_end[slot] > regions.slot_start[slot]) begin
				span = regions.slot_end[slot] - regions.slot_start[slot];
				addr = regions.slot_start[slot] + rand48() % span;
				room = regions.slot_end[slot] - addr;
				case ($urandom_range(0, 3))
					0:       min_bytes = '0;
					1:       min_bytes = room;
					2:       min_bytes = room + 1;
					default: min_bytes = rand48() % (room + 1);
				endcase
			end else begin
				addr = rand48();
				min_bytes = rand48() >> $urandom_range(0, 47);
			end
			send_lookup(addr, min_bytes);
		end else begin
			addr = ($urandom_range(0, 7) == 0) ? '0 : rand48();
			handle = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
			send_word(arrlt_action_t'($urandom_range(0, 1)), addr, rand48(), handle,
				rand48(), $urandom, rand48() >> $urandom_range(0, 47));
		end
	endtask

	// Result side: random stall bursts, stall-free stretches, and one long
	// hold-off on request so that the block backs up and stalls its input.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// Result monitor: a word leaves at the rising edge after a falling edge
	// that sees out_valid high and out_stall low.
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall)
				regions.check_result(status, found_handle, found_end, found_state);
		end
	end

	initial begin
		logic [FIELD_ADDR_W-1:0] cluster;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// two thirds of the starts sit close together so regions overlap and nest
		cluster = rand48();
		cluster[15:0] = '0;
		if (cluster == '0)
			cluster = 'h1_0000;
		for (int k = 0; k < POOL_STARTS; k++)
			pool_start[k] = (k < 8) ? cluster + k * 'h800 : rand48() | 1;
		for (int k = 0; k < POOL_HANDLES; k++)
			pool_handle[k] = $urandom | 1;
		@(posedge clk);

		// Directed: empty table, rejected inserts, field extremes.
		send_lookup('h1, '0);
		send_lookup('0, '0);
		send_insert('h1000, 'h2000, '0, 'h10, $urandom);
		send_insert('h1000, 'h2000, 'h5, '0, $urandom);
		send_insert('0, 'h2000, 'h5, 'h10, $urandom);
		send_insert('h1, ADDR_TOP, HANDLE_TOP, BYTES_TOP, FLAGS_TOP);
		send_lookup('0, '0);
		send_lookup(ADDR_TOP - 1, 'h1);
		send_lookup(ADDR_TOP, '0);
		send_lookup('h1, ADDR_TOP);
		// update in place, then a second handle at the same start
		send_insert('h1, 'h100, HANDLE_TOP, 'h1, 'h5);
		send_insert('h1, 'h200, 'h7, 'h10, 'hA);
		send_lookup('h50, 'h10);
		send_lookup('h150, '0);
		// reach exactly at the end, then one byte past it
		send_lookup('hF0, 'h10);
		send_lookup('hF0, 'h11);
		// a closer start wins over an earlier slot
		send_insert('h40, 'h120, 'h3, 'h40, 'h33);
		send_lookup('h50, '0);
		send_lookup('h30, '0);
		// end below start leaves a region that never matches
		send_insert('h40, 'h30, 'h3, 'h40, 'h44);
		send_lookup('h50, '0);
		send_lookup(ADDR_TOP, ADDR_TOP);

		repeat (150) send_random_word();

		// Fill every free slot with fresh regions, then overflow twice.
		while (regions.free_slots() > 0)
			send_insert(rand48() | 1, rand48(), $urandom | 1, rand48() | 1, $urandom);
		repeat (2) send_insert(rand48() | 1, rand48(), $urandom | 1, rand48() | 1, $urandom);

		// Back up the block behind a long result stall, then drain it fully.
		long_hold_req = 1'b1;
		repeat (8) send_random_word();
		wait_drained(5);

		repeat (130) send_random_word();

		// Last stretch at full rate on both sides.
		quiet = 1'b1;
		repeat (60) send_random_word();
		wait_drained(SETTLE_CYCLES);

		if (regions.mismatches == 0 && regions.expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
